FILE: hw/rtl/srm_pkg.sv
`timescale 1ns / 1ps
// srm_pkg: shared types, widths and helpers of the strain rate magnitude core.
// No dependencies.
package srm_pkg;

    localparam int GW     = 32;           // gradient entry width
    localparam int SW     = GW + 1;       // pair sum / difference width
    localparam int SQW    = 2 * GW + 1;   // square of a SW-bit magnitude
    localparam int ACCW   = SQW + 2;      // sum of three squares
    localparam int NW     = ACCW + 1;     // scaled radicand
    localparam int ROOT_W = GW;           // root width
    localparam int LANES  = 6;

    localparam logic [1:0] DIM_2D = 2'd2;
    localparam logic [1:0] DIM_3D = 2'd3;

    // lanes: off-diagonal pair sums, then diagonal differences
    localparam int L_S01 = 0;
    localparam int L_S02 = 1;
    localparam int L_S12 = 2;
    localparam int L_D01 = 3;
    localparam int L_D12 = 4;
    localparam int L_D20 = 5;

    // radicand bounds at or above which the root exceeds ROOT_W bits
    localparam logic [NW-1:0] SAT_2D = NW'(1) << (2 * ROOT_W);
    localparam logic [NW-1:0] SAT_3D = NW'(3) << (2 * ROOT_W);

    typedef struct packed {
        logic signed [GW-1:0] du_dx;
        logic signed [GW-1:0] du_dy;
        logic signed [GW-1:0] du_dz;
        logic signed [GW-1:0] dv_dx;
        logic signed [GW-1:0] dv_dy;
        logic signed [GW-1:0] dv_dz;
        logic signed [GW-1:0] dw_dx;
        logic signed [GW-1:0] dw_dy;
        logic signed [GW-1:0] dw_dz;
    } t_grad;

    typedef struct packed {
        logic [ROOT_W-1:0] magnitude;
        logic              saturated;
    } t_result;

    typedef struct packed {
        logic vld;
        logic dim3;
    } t_ctl;

    function automatic logic [SW-1:0] sx(input logic [GW-1:0] v);
        return {v[GW-1], v};
    endfunction

endpackage

FILE: hw/rtl/strain_rate_magnitude_core.sv
`timescale 1ns / 1ps
// strain_rate_magnitude_core: deviatoric strain-rate magnitude, one gradient word per cycle.
// Pipeline: 2 prep, 3 square/sum and 32 root stages from input acceptance to o_valid.
// Throughput: one word per cycle; the whole pipe holds while the output word is stalled.
// Reset (synchronous, i_rst_n low): all valid bits cleared, dimension register set to 3.
// Depends on srm_pkg, srm_prep, srm_sumsq, srm_sqrt.
module strain_rate_magnitude_core import srm_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  t_grad      i_data,
    output logic       o_valid,
    input  logic       i_stall,
    output t_result    o_data,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_wdata
);

    logic [1:0]               r_dim;
    logic                     en;
    logic                     dim3;
    t_ctl                     prep_ctl;
    logic [LANES-1:0][SW-1:0] prep_mag;
    t_ctl                     sum_ctl;
    logic [NW-1:0]            sum_rad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim <= DIM_3D;
        end else if (i_cfg_we) begin
            r_dim <= i_cfg_wdata;
        end
    end

    // codes other than 2 run as 3-D
    assign dim3    = (r_dim != DIM_2D);
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    srm_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_dim3  (dim3),
        .i_grad  (i_data),
        .o_ctl   (prep_ctl),
        .o_mag   (prep_mag)
    );

    srm_sumsq u_sumsq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_ctl   (prep_ctl),
        .i_mag   (prep_mag),
        .o_ctl   (sum_ctl),
        .o_rad   (sum_rad)
    );

    srm_sqrt u_sqrt (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_ctl    (sum_ctl),
        .i_rad    (sum_rad),
        .o_valid  (o_valid),
        .o_result (o_data)
    );

endmodule

FILE: hw/rtl/srm_prep.sv
`timescale 1ns / 1ps
// srm_prep: pair sums and diagonal differences of the gradient, then their magnitudes.
// Depends on srm_pkg.
module srm_prep import srm_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  logic                     i_dim3,
    input  t_grad                    i_grad,
    output t_ctl                     o_ctl,
    output logic [LANES-1:0][SW-1:0] o_mag
);

    logic [LANES-1:0][SW-1:0] n_a_val;
    logic [LANES-1:0][SW-1:0] r_a_val;
    t_ctl                     r_a_ctl;
    logic [LANES-1:0][SW-1:0] n_b_mag;
    logic [LANES-1:0][SW-1:0] r_b_mag;
    t_ctl                     r_b_ctl;

    // deviatoric part: in 3-D the diagonal enters only through pairwise differences
    always_comb begin
        n_a_val[L_S01] = sx(i_grad.du_dy) + sx(i_grad.dv_dx);
        n_a_val[L_S02] = sx(i_grad.du_dz) + sx(i_grad.dw_dx);
        n_a_val[L_S12] = sx(i_grad.dv_dz) + sx(i_grad.dw_dy);
        n_a_val[L_D01] = sx(i_grad.du_dx) - sx(i_grad.dv_dy);
        n_a_val[L_D12] = sx(i_grad.dv_dy) - sx(i_grad.dw_dz);
        n_a_val[L_D20] = sx(i_grad.dw_dz) - sx(i_grad.du_dx);
        if (!i_dim3) begin
            n_a_val[L_S02] = '0;
            n_a_val[L_S12] = '0;
            n_a_val[L_D12] = '0;
            n_a_val[L_D20] = '0;
        end
    end

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            n_b_mag[i] = r_a_val[i][SW-1] ? (SW'(0) - r_a_val[i]) : r_a_val[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_ctl <= '0;
            r_b_ctl <= '0;
        end else if (i_en) begin
            r_a_ctl <= '{vld: i_valid, dim3: i_dim3};
            r_b_ctl <= r_a_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_val <= n_a_val;
            r_b_mag <= n_b_mag;
        end
    end

    assign o_ctl = r_b_ctl;
    assign o_mag = r_b_mag;

endmodule

FILE: hw/rtl/srm_sumsq.sv
`timescale 1ns / 1ps
// srm_sumsq: lane squares, the two partial sums and the scaled radicand.
// Depends on srm_pkg.
module srm_sumsq import srm_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  t_ctl                     i_ctl,
    input  logic [LANES-1:0][SW-1:0] i_mag,
    output t_ctl                     o_ctl,
    output logic [NW-1:0]            o_rad
);

    logic [LANES-1:0][SQW-1:0] n_sq;
    logic [LANES-1:0][SQW-1:0] r_sq;
    t_ctl                      r_c_ctl;
    logic [ACCW-1:0]           n_q;
    logic [ACCW-1:0]           n_p;
    logic [ACCW-1:0]           r_q;
    logic [ACCW-1:0]           r_p;
    t_ctl                      r_d_ctl;
    logic [NW-1:0]             n_rad;
    logic [NW-1:0]             r_rad;
    t_ctl                      r_e_ctl;

    // a magnitude with its top bit set is exactly 2^GW, so a GW x GW product covers the rest
    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            logic [2*GW-1:0] prod;
            prod = i_mag[i][GW-1:0] * i_mag[i][GW-1:0];
            n_sq[i] = i_mag[i][SW-1] ? (SQW'(1) << (2 * GW)) : {1'b0, prod};
        end
    end

    assign n_q = ACCW'(r_sq[L_S01]) + ACCW'(r_sq[L_S02]) + ACCW'(r_sq[L_S12]);
    assign n_p = ACCW'(r_sq[L_D01]) + ACCW'(r_sq[L_D12]) + ACCW'(r_sq[L_D20]);

    // 3-D: root of (3Q + 2P) / 3 is taken by weighting the trial square by 3
    always_comb begin
        if (r_d_ctl.dim3) begin
            n_rad = NW'(r_q) + (NW'(r_q) << 1) + (NW'(r_p) << 1);
        end else begin
            n_rad = NW'(r_q) + NW'(r_p);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_ctl <= '0;
            r_d_ctl <= '0;
            r_e_ctl <= '0;
        end else if (i_en) begin
            r_c_ctl <= i_ctl;
            r_d_ctl <= r_c_ctl;
            r_e_ctl <= r_d_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq  <= n_sq;
            r_q   <= n_q;
            r_p   <= n_p;
            r_rad <= n_rad;
        end
    end

    assign o_ctl = r_e_ctl;
    assign o_rad = r_rad;

endmodule

FILE: hw/rtl/srm_sqrt.sv
`timescale 1ns / 1ps
// srm_sqrt: pipelined restoring square root, one root bit per stage, with saturation.
// Depends on srm_pkg.
module srm_sqrt import srm_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  t_ctl          i_ctl,
    input  logic [NW-1:0] i_rad,
    output logic          o_valid,
    output t_result       o_result
);

    logic              r_vld  [ROOT_W];
    logic              r_sat  [ROOT_W];
    logic [ROOT_W-1:0] r_root [ROOT_W];
    logic              r_dim3 [ROOT_W-1];
    logic [NW-1:0]     r_rem  [ROOT_W-1];

    for (genvar j = 0; j < ROOT_W; j++) begin : g_stage
        localparam int B = ROOT_W - 1 - j;

        logic              c_vld;
        logic              c_sat;
        logic              c_dim3;
        logic [ROOT_W-1:0] c_root;
        logic [NW-1:0]     c_rem;
        logic [NW-1:0]     trial;
        logic [NW-1:0]     ktrial;
        logic              fit;

        if (j == 0) begin : g_first
            assign c_vld  = i_ctl.vld;
            assign c_dim3 = i_ctl.dim3;
            assign c_root = '0;
            assign c_rem  = i_rad;
            assign c_sat  = i_ctl.dim3 ? (i_rad >= SAT_3D) : (i_rad >= SAT_2D);
        end else begin : g_next
            assign c_vld  = r_vld[j-1];
            assign c_dim3 = r_dim3[j-1];
            assign c_root = r_root[j-1];
            assign c_rem  = r_rem[j-1];
            assign c_sat  = r_sat[j-1];
        end

        // k*((r + 2^B)^2 - r^2) = k*(r*2^(B+1) + 2^(2B)), bits do not overlap
        assign trial  = (NW'(c_root) << (B + 1)) | (NW'(1) << (2 * B));
        assign ktrial = c_dim3 ? (trial + (trial << 1)) : trial;
        assign fit    = (ktrial <= c_rem);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else if (i_en) begin
                r_vld[j] <= c_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sat[j]  <= c_sat;
                r_root[j] <= fit ? (c_root | (ROOT_W'(1) << B)) : c_root;
            end
        end

        if (j < ROOT_W - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_dim3[j] <= c_dim3;
                    r_rem[j]  <= fit ? (c_rem - ktrial) : c_rem;
                end
            end
        end
    end

    assign o_valid            = r_vld[ROOT_W-1];
    assign o_result.magnitude = r_sat[ROOT_W-1] ? '1 : r_root[ROOT_W-1];
    assign o_result.saturated = r_sat[ROOT_W-1];

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// testbench: self-checking bench for strain_rate_magnitude_core, with an exact 128-bit
// predictor, directed corner words, random gradients and random idling on both sides.
// Depends on srm_pkg and the core RTL.
module testbench;
    import srm_pkg::*;

    localparam int  HALF_PERIOD = 6;
    localparam int  CORE_LATENCY = 37;
    localparam int  CYCLE_LIMIT = 400000;
    localparam int  PRINT_LIMIT = 30;

    // dimension codes outside 2 and 3 behave as 3-D
    localparam logic [1:0] DIM_CODE0 = 2'd0;
    localparam logic [1:0] DIM_CODE1 = 2'd1;

    localparam logic [GW-1:0] Q_MAX  = 32'h7FFF_FFFF;
    localparam logic [GW-1:0] Q_MIN  = 32'h8000_0000;
    localparam logic [GW-1:0] Q_ONE  = 32'h0001_0000;
    localparam logic [GW-1:0] Q_ZERO = 32'h0000_0000;
    localparam logic [GW-1:0] Q_NEG1 = 32'hFFFF_FFFF;
    localparam logic [GW-1:0] Q_LSB  = 32'h0000_0001;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    t_grad      i_data = '0;
    logic       o_valid;
    logic       i_stall = 1'b0;
    t_result    o_data;
    logic       i_cfg_we = 1'b0;
    logic [1:0] i_cfg_wdata = DIM_3D;

    logic [1:0] dim_code = DIM_3D;   // bench copy of the dimension register
    logic       idle_on = 1'b1;
    int         stall_left = 0;
    int         cycle_count = 0;
    int         err_count = 0;
    int         words_sent = 0;
    int         words_checked = 0;
    int         sat_seen = 0;

    t_result    mag_expected_q[$];

    strain_rate_magnitude_core u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_data     (o_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // exact magnitude: sum of squared scaled deviatoric terms, divided, then floor sqrt
    function automatic t_result predict_strain_mag(input t_grad g, input logic [1:0] dcode);
        longint     e[3][3];
        longint     tr;
        longint     a;
        longint     nd;
        logic [127:0] m;
        logic [127:0] sum;
        logic [127:0] radicand;
        logic [63:0]  root;
        logic [63:0]  cand;
        t_result      res;
        e[0][0] = g.du_dx; e[0][1] = g.du_dy; e[0][2] = g.du_dz;
        e[1][0] = g.dv_dx; e[1][1] = g.dv_dy; e[1][2] = g.dv_dz;
        e[2][0] = g.dw_dx; e[2][1] = g.dw_dy; e[2][2] = g.dw_dz;
        nd = (dcode == DIM_2D) ? 2 : 3;
        tr = 0;
        for (int i = 0; i < nd; i++) tr += e[i][i];
        sum = '0;
        for (int i = 0; i < nd; i++) begin
            for (int j = 0; j < nd; j++) begin
                if (i == j) a = 2 * (nd * e[i][i] - tr);
                else        a = nd * (e[i][j] + e[j][i]);
                if (a < 0) a = -a;
                m = 128'(a);
                sum += m * m;
            end
        end
        radicand = sum / 128'(2 * nd * nd);
        root = '0;
        for (int b = 63; b >= 0; b--) begin
            cand = root | (64'd1 << b);
            if (128'(cand) * 128'(cand) <= radicand) root = cand;
        end
        if (root > 64'h0000_0000_FFFF_FFFF) begin
            res.magnitude = '1;
            res.saturated = 1'b1;
        end else begin
            res.magnitude = root[ROOT_W-1:0];
            res.saturated = 1'b0;
        end
        return res;
    endfunction

    function automatic t_grad grad_of(input logic [GW-1:0] xx, xy, xz, yx, yy, yz,
                                      zx, zy, zz);
        t_grad g;
        g.du_dx = xx; g.du_dy = xy; g.du_dz = xz;
        g.dv_dx = yx; g.dv_dy = yy; g.dv_dz = yz;
        g.dw_dx = zx; g.dw_dy = zy; g.dw_dz = zz;
        return g;
    endfunction

    function automatic logic [GW-1:0] rand_entry();
        logic [GW-1:0] r;
        r = $urandom;
        case ($urandom_range(0, 5))
            0, 1: return r;
            2: return {{16{r[15]}}, r[15:0]};
            3: return {{8{r[23]}}, r[23:0]};
            4: begin
                case ($urandom_range(0, 4))
                    0: return Q_MAX;
                    1: return Q_MIN;
                    2: return Q_ZERO;
                    3: return Q_NEG1;
                    default: return Q_LSB;
                endcase
            end
            default: return r[31] ? Q_MIN + r[11:0] : Q_MAX - r[11:0];
        endcase
    endfunction

    function automatic t_grad rand_grad();
        t_grad g;
        g = grad_of(rand_entry(), rand_entry(), rand_entry(), rand_entry(), rand_entry(),
                    rand_entry(), rand_entry(), rand_entry(), rand_entry());
        // near divergence-free flow now and then
        if ($urandom_range(0, 7) == 0) g.dw_dz = -(g.du_dx + g.dv_dy);
        return g;
    endfunction

    // present one word, hold it until accepted, then maybe leave a gap
    task automatic send_grad(input t_grad g);
        int gap;
        i_data  <= g;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        mag_expected_q.push_back(predict_strain_mag(g, dim_code));
        words_sent++;
        // every fourth stretch of 32 words runs without input gaps
        if (idle_on && (words_sent / 32) % 4 != 3 && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 11);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_results();
        i_valid <= 1'b0;
        while (mag_expected_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_dimension(input logic [1:0] code);
        wait_results();
        i_cfg_wdata <= code;
        i_cfg_we    <= 1'b1;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        dim_code = code;
    endtask

    task automatic send_random(input int count);
        for (int k = 0; k < count; k++) send_grad(rand_grad());
    endtask

    task automatic test_reset_default();
        // dimension left at its reset value of 3
        send_grad(grad_of(Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO,
                          Q_ZERO));
        send_grad(grad_of(Q_ONE, Q_ZERO, Q_ZERO, Q_ZERO, Q_ONE, Q_ZERO, Q_ZERO, Q_ZERO,
                          Q_ONE));
    endtask

    task automatic test_extremes_3d();
        write_dimension(DIM_3D);
        send_grad(grad_of(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX));
        send_grad(grad_of(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN));
        send_grad(grad_of(Q_ZERO, Q_MAX, Q_MAX, Q_MAX, Q_ZERO, Q_MAX, Q_MAX, Q_MAX,
                          Q_ZERO));
        send_grad(grad_of(Q_MAX, Q_ZERO, Q_ZERO, Q_ZERO, Q_MIN, Q_ZERO, Q_ZERO, Q_ZERO,
                          Q_ZERO));
        send_grad(grad_of(Q_ZERO, Q_MAX, Q_ZERO, Q_MIN, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO,
                          Q_ZERO));
        send_grad(grad_of(Q_ZERO, Q_ONE, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO,
                          Q_ZERO));
        send_grad(grad_of(Q_NEG1, Q_NEG1, Q_NEG1, Q_NEG1, Q_NEG1, Q_NEG1, Q_NEG1, Q_NEG1,
                          Q_NEG1));
        send_grad(grad_of(Q_LSB, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO,
                          Q_ZERO));
        send_grad(grad_of(Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MIN, Q_MAX));
    endtask

    task automatic test_plane_strain();
        write_dimension(DIM_2D);
        // z terms at full scale must not matter
        send_grad(grad_of(Q_ZERO, Q_ZERO, Q_MAX, Q_ZERO, Q_ZERO, Q_MIN, Q_MAX, Q_MIN,
                          Q_MAX));
        send_grad(grad_of(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX));
        send_grad(grad_of(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN));
        send_grad(grad_of(Q_MAX, Q_ZERO, Q_ZERO, Q_ZERO, Q_MIN, Q_ZERO, Q_ZERO, Q_ZERO,
                          Q_ZERO));
        send_grad(grad_of(Q_ZERO, Q_ONE, Q_NEG1, Q_ONE, Q_ZERO, Q_LSB, Q_ONE, Q_ONE,
                          Q_ONE));
    endtask

    task automatic test_dimension_codes();
        write_dimension(DIM_CODE0);
        send_grad(grad_of(Q_MAX, Q_ONE, Q_MIN, Q_ZERO, Q_NEG1, Q_ONE, Q_MAX, Q_LSB, Q_MIN));
        send_grad(grad_of(Q_ZERO, Q_ZERO, Q_MAX, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO,
                          Q_ZERO));
        write_dimension(DIM_CODE1);
        send_grad(grad_of(Q_MAX, Q_ONE, Q_MIN, Q_ZERO, Q_NEG1, Q_ONE, Q_MAX, Q_LSB, Q_MIN));
        send_grad(grad_of(Q_ONE, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO,
                          Q_ZERO));
    endtask

    task automatic test_random_mix();
        write_dimension(DIM_3D);
        send_random(600);
        write_dimension(DIM_2D);
        send_random(500);
        write_dimension(DIM_CODE0);
        send_random(200);
        write_dimension(DIM_CODE1);
        send_random(150);
        write_dimension(DIM_3D);
        send_random(250);
    endtask

    task automatic test_steady_stream();
        idle_on <= 1'b0;
        write_dimension(DIM_2D);
        send_random(100);
        write_dimension(DIM_3D);
        send_random(100);
    endtask

    // output side back-pressure in random bursts
    always @(posedge i_clk) begin
        if (!idle_on) begin
            i_stall    <= 1'b0;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 2) == 0) begin
            i_stall    <= 1'b1;
            stall_left <= $urandom_range(0, 10);
        end else begin
            i_stall    <= 1'b0;
            stall_left <= $urandom_range(0, 15);
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (mag_expected_q.size() == 0) begin
                err_count++;
                if (err_count <= PRINT_LIMIT)
                    $display("%0t: unexpected word, actual magnitude %h saturated %b",
                             $time, o_data.magnitude, o_data.saturated);
            end else begin
                want = mag_expected_q.pop_front();
                words_checked++;
                if (want.saturated) sat_seen++;
                if (o_data.magnitude !== want.magnitude) begin
                    err_count++;
                    if (err_count <= PRINT_LIMIT)
                        $display("%0t: magnitude expected %h actual %h", $time,
                                 want.magnitude, o_data.magnitude);
                end
                if (o_data.saturated !== want.saturated) begin
                    err_count++;
                    if (err_count <= PRINT_LIMIT)
                        $display("%0t: saturated expected %b actual %b", $time,
                                 want.saturated, o_data.saturated);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d words outstanding", $time,
                     mag_expected_q.size());
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_default();
        test_extremes_3d();
        test_plane_strain();
        test_dimension_codes();
        test_random_mix();
        test_steady_stream();
        wait_results();
        repeat (CORE_LATENCY + 10) @(posedge i_clk);
        if (mag_expected_q.size() != 0) err_count++;
        $display("Sent %0d gradient words over dimension codes 0..3, checked %0d results,",
                 words_sent, words_checked);
        $display("%0d of them saturated; %0d failures.", sat_seen, err_count);
        if (err_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
